### rtl/mesc_pkg.sv
// ----------------------------------------------------------------------------
// mesc_pkg: shared types for the expression syntax checker
// Error codes, character classes and the per-expression flag bundle.
// ----------------------------------------------------------------------------
package mesc_pkg;

  localparam int unsigned SymbolW = 8;
  localparam int unsigned ErrW    = 4;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE        = 4'd0,
    ERR_NUM_EXPECT  = 4'd1,
    ERR_SYNTAX      = 4'd2,
    ERR_NUM_SYNTAX  = 4'd3,
    ERR_OP_BEF_NUM  = 4'd4,
    ERR_OP_BEF_CLS  = 4'd5,
    ERR_BAD_CLOSE   = 4'd6,
    ERR_EMPTY_PAREN = 4'd7,
    ERR_OP_BEF_OPEN = 4'd8,
    ERR_ADJ_OPS     = 4'd9,
    ERR_MISMATCH    = 4'd10,
    ERR_TRAIL_OP    = 4'd11,
    ERR_TOO_DEEP    = 4'd12
  } err_e;

  typedef enum logic [3:0] {
    CC_SEP,
    CC_DIGIT,
    CC_DOT,
    CC_EXP,
    CC_OPEN,
    CC_CLOSE,
    CC_PLUS,
    CC_MINUS,
    CC_MULDIV,
    CC_BAD
  } char_class_e;

  typedef struct packed {
    logic in_number;
    logic in_decimal;
    logic in_exponent;
    logic digit_required;
    logic operand_last;
    logic previous_was_open;
  } flags_t;

  function automatic char_class_e classify(input logic [SymbolW-1:0] c);
    char_class_e cls;
    cls = CC_BAD;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls = CC_DIGIT;
    end else begin
      case (c)
        8'h20, 8'h0A: cls = CC_SEP;
        8'h2E:        cls = CC_DOT;
        8'h65:        cls = CC_EXP;
        8'h28:        cls = CC_OPEN;
        8'h29:        cls = CC_CLOSE;
        8'h2B:        cls = CC_PLUS;
        8'h2D:        cls = CC_MINUS;
        8'h2A, 8'h2F, 8'h25: cls = CC_MULDIV;
        default:      cls = CC_BAD;
      endcase
    end
    return cls;
  endfunction

endpackage

### rtl/math_expression_syntax_check.sv
// ----------------------------------------------------------------------------
// math_expression_syntax_check: streaming arithmetic expression checker
// Takes one character per word and gives one verdict word per expression.
//
//   Channel  Dir  Contents
//   s_axis   in   tdata = symbol[7:0], tlast = end of expression
//   m_axis   out  tdata = ok[0], error_code[4:1], zero-filled to 8 bits
//
// One word is taken every cycle unless an end word waits on a held verdict; a
// character goes through an input register and then a single step of flag
// logic. An end word passes through the input register and then the verdict
// register. Reset empties both registers and returns the checker to the start
// of an expression. Only an end word waits on a held verdict; characters keep
// flowing while the output is stalled.
// ----------------------------------------------------------------------------
module math_expression_syntax_check #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  logic       s_axis_tlast_i,   // kind: end of expression
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] ok, [4:1] error_code, [7:5] zero
);
  import mesc_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

  logic               stg_valid_q, stg_valid_d;
  logic               stg_last_q;
  logic [SymbolW-1:0] stg_symbol_q;
  logic               stg_fire;

  flags_t             flags_q, flags_d, step_flags;
  logic [DEPTH_W-1:0] depth_q, depth_d, step_depth;
  err_e               first_error_q, first_error_d, char_err, end_err;

  logic               res_valid_q, res_valid_d;
  err_e               res_err_q;
  logic               res_ok_q;

  assign stg_fire        = stg_valid_q & (~stg_last_q | ~res_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~stg_valid_q | stg_fire;
  assign stg_valid_d     = (s_axis_tvalid_i & s_axis_tready_o) | (stg_valid_q & ~stg_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      stg_last_q   <= s_axis_tlast_i;
      stg_symbol_q <= s_axis_tdata_i;
    end
  end

  mesc_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W)
  ) u_step (
    .flags_i    (flags_q),
    .depth_i    (depth_q),
    .symbol_i   (stg_symbol_q),
    .flags_o    (step_flags),
    .depth_o    (step_depth),
    .char_err_o (char_err),
    .end_err_o  (end_err)
  );

  // Once an error is latched, the other state no longer matters until the end.
  always_comb begin
    flags_d       = flags_q;
    depth_d       = depth_q;
    first_error_d = first_error_q;
    if (stg_fire) begin
      if (stg_last_q) begin
        flags_d       = '0;
        depth_d       = '0;
        first_error_d = ERR_NONE;
      end else if (first_error_q == ERR_NONE) begin
        flags_d       = step_flags;
        first_error_d = char_err;
        // An open past the limit or a stray close leaves the depth in range.
        if (char_err == ERR_NONE) depth_d = step_depth;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      depth_q       <= '0;
      first_error_q <= ERR_NONE;
    end else begin
      flags_q       <= flags_d;
      depth_q       <= depth_d;
      first_error_q <= first_error_d;
    end
  end

  assign res_valid_d = (stg_fire & stg_last_q) | (res_valid_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_fire && stg_last_q) begin
      if (first_error_q != ERR_NONE) begin
        res_err_q <= first_error_q;
        res_ok_q  <= 1'b0;
      end else begin
        res_err_q <= end_err;
        res_ok_q  <= (end_err == ERR_NONE);
      end
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_err_q, res_ok_q};

  a_depth_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond its limit");

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_fire && stg_last_q) |=> (depth_q == '0 && first_error_q == ERR_NONE &&
                                  flags_q == '0))
    else $error("state not cleared after end of expression");

  a_error_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_error_q != ERR_NONE && !(stg_fire && stg_last_q)) |=> $stable(first_error_q))
    else $error("latched error changed before end of expression");

  a_ok_matches_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_ok_q == (res_err_q == ERR_NONE)))
    else $error("verdict flag disagrees with error code");

endmodule

### rtl/mesc_step.sv
// ----------------------------------------------------------------------------
// mesc_step: next-state logic of the syntax checker
// Works out the flags, nesting depth and error for one character, and the
// error for the end of an expression.
// ----------------------------------------------------------------------------
module mesc_step #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned DEPTH_W   = 8
) (
  input  mesc_pkg::flags_t             flags_i,
  input  logic [DEPTH_W-1:0]           depth_i,
  input  logic [mesc_pkg::SymbolW-1:0] symbol_i,
  output mesc_pkg::flags_t             flags_o,
  output logic [DEPTH_W-1:0]           depth_o,
  output mesc_pkg::err_e               char_err_o,
  output mesc_pkg::err_e               end_err_o
);
  import mesc_pkg::*;

  char_class_e cls;
  flags_t      closed;
  logic        end_operand;

  assign cls = classify(symbol_i);

  // Flags once any number in progress has been closed off.
  always_comb begin
    closed = flags_i;
    if (flags_i.in_number) begin
      closed.in_number    = 1'b0;
      closed.in_decimal   = 1'b0;
      closed.in_exponent  = 1'b0;
      closed.operand_last = 1'b1;
    end
  end

  always_comb begin
    flags_o    = flags_i;
    depth_o    = depth_i;
    char_err_o = ERR_NONE;
    case (cls)
      CC_SEP: begin
        if (flags_i.digit_required) char_err_o = ERR_NUM_EXPECT;
        flags_o = closed;
      end
      CC_DIGIT: begin
        if (flags_i.operand_last) char_err_o = ERR_OP_BEF_NUM;
        flags_o.digit_required = 1'b0;
        flags_o.in_number      = 1'b1;
      end
      CC_DOT: begin
        if (!flags_i.in_number) char_err_o = ERR_SYNTAX;
        else if (flags_i.in_decimal) char_err_o = ERR_NUM_SYNTAX;
        else if (flags_i.operand_last) char_err_o = ERR_OP_BEF_NUM;
        flags_o.digit_required = 1'b0;
        flags_o.in_decimal     = 1'b1;
        flags_o.in_number      = 1'b1;
      end
      CC_EXP: begin
        if (flags_i.in_exponent) char_err_o = ERR_NUM_SYNTAX;
        else if (flags_i.operand_last) char_err_o = ERR_OP_BEF_NUM;
        flags_o.in_exponent    = 1'b1;
        flags_o.digit_required = 1'b1;
        flags_o.in_number      = 1'b1;
      end
      CC_CLOSE: begin
        if (flags_i.digit_required) char_err_o = ERR_NUM_EXPECT;
        else if (!closed.operand_last) char_err_o = ERR_OP_BEF_CLS;
        else if (depth_i == '0) char_err_o = ERR_BAD_CLOSE;
        else if (flags_i.previous_was_open) char_err_o = ERR_EMPTY_PAREN;
        flags_o = closed;
        depth_o = depth_i - DEPTH_W'(1);
      end
      CC_OPEN: begin
        if (flags_i.digit_required) char_err_o = ERR_NUM_EXPECT;
        else if (closed.operand_last) char_err_o = ERR_OP_BEF_OPEN;
        else if (depth_i >= DEPTH_W'(MAX_DEPTH)) char_err_o = ERR_TOO_DEEP;
        flags_o              = closed;
        flags_o.operand_last = 1'b0;
        depth_o              = depth_i + DEPTH_W'(1);
      end
      CC_PLUS, CC_MINUS, CC_MULDIV: begin
        if (cls == CC_MINUS && flags_i.in_number && flags_i.in_exponent) begin
          // A minus sign anywhere in a number's open exponent belongs to the number.
          flags_o.digit_required = 1'b1;
        end else begin
          if (flags_i.digit_required) char_err_o = ERR_NUM_EXPECT;
          else if (cls == CC_MULDIV && !closed.operand_last) char_err_o = ERR_ADJ_OPS;
          flags_o              = closed;
          flags_o.operand_last = 1'b0;
        end
      end
      default: begin
        char_err_o = ERR_SYNTAX;
      end
    endcase
    flags_o.previous_was_open = (cls == CC_OPEN);
  end

  // An unfinished exponent is still taken as a number at the end.
  always_comb begin
    end_err_o   = ERR_NONE;
    end_operand = flags_i.operand_last | flags_i.in_number;
    if (!flags_i.in_number && flags_i.digit_required) end_err_o = ERR_NUM_EXPECT;
    else if (depth_i != '0) end_err_o = ERR_MISMATCH;
    else if (!end_operand) end_err_o = ERR_TRAIL_OP;
  end

endmodule

### tb/math_expression_syntax_check_test.sv
// ----------------------------------------------------------------------------
// math_expression_syntax_check_test: self-checking bench for the syntax checker
// Streams expressions into the checker one character word at a time. A
// behavioural copy of the checker predicts the verdict for every end word.
// Each verdict word taken from the output is compared against the oldest
// prediction. The run has four phases with different amounts of source idling
// and sink back-pressure.
// ----------------------------------------------------------------------------
module math_expression_syntax_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mesc_pkg::*;

  localparam int unsigned MaxDepth      = 255;
  localparam int unsigned WordsPerPhase = 490;
  localparam int unsigned CycleLimit    = 400000;

  typedef struct packed {
    logic               last;
    logic [SymbolW-1:0] symbol;
  } char_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  char_word_t  word_q[$];
  err_e        verdict_q[$];
  logic [7:0]  expr_buf[$];
  string       char_pool = "0123456789.e+-*/%() \nxa";
  char_word_t  next_word;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_made = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  logic        word_taken = 1'b0;
  err_e        want;

  // Behavioural copy of the checker state.
  logic        num_open = 1'b0;
  logic        num_dot = 1'b0;
  logic        num_exp = 1'b0;
  logic        need_digit = 1'b0;
  logic        have_operand = 1'b0;
  logic        after_open = 1'b0;
  int unsigned depth = 0;
  err_e        latched_err = ERR_NONE;

  math_expression_syntax_check #(
    .MAX_DEPTH(MaxDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic void end_number();
    if (num_open) begin
      num_open = 1'b0;
      num_dot = 1'b0;
      num_exp = 1'b0;
      have_operand = 1'b1;
    end
  endfunction

  // Advances the checker copy by one character and returns the error it raises.
  function automatic err_e scan_symbol(input logic [7:0] c);
    logic digitlike;
    logic op;
    digitlike = (c >= "0" && c <= "9") || c == "." || c == "e";
    op = c == "+" || c == "-" || c == "*" || c == "/" || c == "%";
    if (c == " " || c == "\n") begin
      if (need_digit) return ERR_NUM_EXPECT;
      end_number();
    end else if (digitlike) begin
      need_digit = 1'b0;
      if (c == ".") begin
        if (!num_open) return ERR_SYNTAX;
        if (num_dot) return ERR_NUM_SYNTAX;
        num_dot = 1'b1;
      end
      if (c == "e") begin
        if (num_exp) return ERR_NUM_SYNTAX;
        num_exp = 1'b1;
        need_digit = 1'b1;
      end
      if (have_operand) return ERR_OP_BEF_NUM;
      num_open = 1'b1;
    end else if (c == ")") begin
      if (need_digit) return ERR_NUM_EXPECT;
      end_number();
      if (!have_operand) return ERR_OP_BEF_CLS;
      if (depth == 0) return ERR_BAD_CLOSE;
      depth--;
      if (after_open) return ERR_EMPTY_PAREN;
    end else if (c == "(") begin
      if (need_digit) return ERR_NUM_EXPECT;
      end_number();
      if (have_operand) return ERR_OP_BEF_OPEN;
      if (depth >= MaxDepth) return ERR_TOO_DEEP;
      depth++;
      have_operand = 1'b0;
    end else if (op) begin
      // A minus while a number's exponent is open belongs to the number.
      if (c == "-" && num_open && num_exp) begin
        need_digit = 1'b1;
      end else begin
        if (need_digit) return ERR_NUM_EXPECT;
        end_number();
        if (c != "-" && c != "+" && !have_operand) return ERR_ADJ_OPS;
        have_operand = 1'b0;
      end
    end else begin
      return ERR_SYNTAX;
    end
    after_open = (c == "(");
    return ERR_NONE;
  endfunction

  function automatic logic [7:0] random_symbol();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return char_pool[$urandom_range(char_pool.len() - 1)];
  endfunction

  task automatic push_symbol(input logic [7:0] c);
    word_q.insert(word_q.size(), char_word_t'{last: 1'b0, symbol: c});
    words_made++;
  endtask

  // The symbol of an end word is meaningless, so it is left random.
  task automatic push_end();
    word_q.insert(word_q.size(), char_word_t'{last: 1'b1, symbol: 8'($urandom_range(255))});
    words_made++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_symbol(s[i]);
    push_end();
  endtask

  task automatic add_char(input logic [7:0] c);
    expr_buf.insert(expr_buf.size(), c);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(4) == 0) add_char($urandom_range(3) == 0 ? "\n" : " ");
  endtask

  // Builds a well-formed expression in expr_buf, then may damage it.
  task automatic build_expression(input int unsigned max_nest, input int unsigned max_terms);
    int unsigned nest;
    int unsigned terms;
    int unsigned pos;
    logic        want_operand;
    expr_buf.delete();
    nest = 0;
    terms = 0;
    want_operand = 1'b1;
    while (1) begin
      if (want_operand) begin
        if ($urandom_range(3) == 0) add_char($urandom_range(1) ? "-" : "+");
        if (nest < max_nest && $urandom_range(2) == 0) begin
          add_char("(");
          nest++;
        end else begin
          if ($urandom_range(9) == 0) begin
            add_char("e");
          end else begin
            repeat ($urandom_range(1, 3)) add_char(8'("0" + $urandom_range(9)));
            if ($urandom_range(2) == 0) begin
              add_char(".");
              repeat ($urandom_range(2)) add_char(8'("0" + $urandom_range(9)));
            end
            if ($urandom_range(3) == 0) begin
              add_char("e");
              if ($urandom_range(1)) add_char("-");
            end
          end
          repeat ($urandom_range(1, 2)) add_char(8'("0" + $urandom_range(9)));
          want_operand = 1'b0;
          terms++;
        end
      end else if (nest > 0 && (terms >= max_terms || $urandom_range(2) == 0)) begin
        add_char(")");
        nest--;
      end else if (terms >= max_terms) begin
        break;
      end else begin
        case ($urandom_range(4))
          0: add_char("+");
          1: add_char("-");
          2: add_char("*");
          3: add_char("/");
          default: add_char("%");
        endcase
        want_operand = 1'b1;
      end
      maybe_gap();
    end
    pos = $urandom_range(99);
    if (pos >= 90) begin
      expr_buf.delete();
      repeat ($urandom_range(10)) add_char(random_symbol());
    end else if (pos >= 65) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(expr_buf.size());
        case ($urandom_range(2))
          0: expr_buf.insert(pos, random_symbol());
          1: if (pos < expr_buf.size()) expr_buf[pos] = random_symbol();
          default: if (pos < expr_buf.size()) expr_buf.delete(pos);
        endcase
      end
    end
    foreach (expr_buf[i]) push_symbol(expr_buf[i]);
    push_end();
  endtask

  // Source side: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || word_taken)) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = word_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_word.symbol;
        s_tlast <= next_word.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    if (rst_ni) m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Predicts on every word taken and checks every verdict word delivered.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      word_taken = s_tvalid && s_tready;
      if (word_taken) begin
        if (!s_tlast) begin
          if (latched_err == ERR_NONE) latched_err = scan_symbol(s_tdata);
        end else begin
          if (latched_err == ERR_NONE) begin
            // A number still waiting for a digit is accepted at the end.
            if (num_open) end_number();
            else if (need_digit) latched_err = ERR_NUM_EXPECT;
            if (latched_err == ERR_NONE) begin
              if (depth != 0) latched_err = ERR_MISMATCH;
              else if (!have_operand) latched_err = ERR_TRAIL_OP;
            end
          end
          verdict_q.insert(verdict_q.size(), latched_err);
          num_open = 1'b0;
          num_dot = 1'b0;
          num_exp = 1'b0;
          need_digit = 1'b0;
          have_operand = 1'b0;
          after_open = 1'b0;
          depth = 0;
          latched_err = ERR_NONE;
        end
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("verdict word %h with none predicted", m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== (want == ERR_NONE) || m_tdata[4:1] !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("verdict mismatch: expected ok=%0b code=%0d, got ok=%0b code=%0d",
                       want == ERR_NONE, want, m_tdata[0], m_tdata[4:1]);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 80;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      if (phase == 0) begin
        push_text("1+2");
        push_text("");
        push_text("1e");
        push_text("1e-");
        push_text("e");
        push_text("1e ");
        push_text(".5");
        push_text("1.2.3");
        push_text("1e2e");
        push_text("1 2");
        push_text("(1+)");
        push_text(")");
        push_text("()");
        push_text("2(");
        push_text("1**2");
        push_text("(1");
        push_text("1+");
        push_text("a");
        push_text("1e-5 *(-3)");
        push_text("1\n%2");
        push_text(")1+2");
        push_text("(((4)))/7.25");
        push_symbol(8'h00);
        push_end();
        push_symbol(8'hFF);
        push_end();
      end
      if (phase == 1) begin
        // Nesting right at the limit, then one level past it.
        repeat (MaxDepth) push_symbol("(");
        push_symbol("7");
        repeat (MaxDepth) push_symbol(")");
        push_end();
        repeat (MaxDepth + 1) push_symbol("(");
        push_end();
      end
      while (words_made < WordsPerPhase * (phase + 1)) begin
        build_expression($urandom_range(4), $urandom_range(1, 5));
      end
      while (word_q.size() != 0 || s_tvalid) @(posedge clk_i);
    end

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    fail_count += verdict_q.size();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
